// ===== src/noise_channel_lfsr_envelope_macros.svh =====
// Assertion macros for the noise channel block.
// Users supply clk and rst in the scope where a macro is expanded.
`ifndef NOISE_CHANNEL_LFSR_ENVELOPE_MACROS_SVH
`define NOISE_CHANNEL_LFSR_ENVELOPE_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define NCLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define NCLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ncle_pkg.sv =====
// Shared types, codes and constant tables for the noise channel block.
// No dependencies; every other file but the macro header imports this package.
package ncle_pkg;

  // Field widths
  localparam int OP_W        = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4;
  localparam int SAMPLE_W    = 8;
  localparam int VOL_W       = 4;
  localparam int RELOAD_W    = 22;
  localparam int LFSR_W      = 15;
  localparam int LEN_W       = 7;
  localparam int DIV_W       = 7;

  // Event codes
  localparam logic [OP_W-1:0] OP_LFSR_STEP    = 3'd0;
  localparam logic [OP_W-1:0] OP_LENGTH_CLOCK = 3'd1;
  localparam logic [OP_W-1:0] OP_ENV_CLOCK    = 3'd2;
  localparam logic [OP_W-1:0] OP_TRIGGER      = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_SAMPLE  = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR_SELECT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SHIFT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VOLUME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE_UP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE_PERIOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_GATE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN     = 3'd7;

  // Channel constants
  localparam logic [LFSR_W-1:0] LFSR_SEED      = 15'h7FFF;
  localparam int                LFSR_TOP_BIT   = 14;
  localparam int                LFSR_SHORT_BIT = 6;
  localparam logic [LEN_W-1:0]  LEN_FULL       = 7'd64;
  localparam logic [LEN_W-1:0]  LEN_SHORT      = 7'd63;
  localparam logic [VOL_W-1:0]  VOL_MAX        = 4'd15;
  localparam logic [VOL_W-1:0]  GAIN_RESET     = 4'd1;

  localparam logic [DIV_W-1:0] DIVISOR_TABLE [8] = '{
    7'd8, 7'd16, 7'd32, 7'd48, 7'd64, 7'd80, 7'd96, 7'd112
  };

  // Configuration register bank contents
  typedef struct packed {
    logic [2:0]       divisor_select;
    logic [3:0]       freq_shift;
    logic             short_mode;
    logic [VOL_W-1:0] start_volume;
    logic             envelope_up;
    logic [2:0]       envelope_period;
    logic             length_gate;
    logic [3:0]       output_gain;
  } ncle_cfg_t;

  // Register bank after reset: all zero but the gain
  localparam ncle_cfg_t CFG_RESET = '{
    divisor_select:  3'd0,
    freq_shift:      4'd0,
    short_mode:      1'b0,
    start_volume:    4'd0,
    envelope_up:     1'b0,
    envelope_period: 3'd0,
    length_gate:     1'b0,
    output_gain:     GAIN_RESET
  };

  // Envelope timer reload: period zero reloads eight
  function automatic logic [3:0] env_reload(input logic [2:0] period);
    env_reload = (period == 3'd0) ? 4'd8 : {1'b0, period};
  endfunction

endpackage

// ===== src/ncle_if.sv =====
// Valid/ready channel interfaces: event input, result output, register writes.
// Depends on ncle_pkg for field widths.
interface ncle_in_if;
  import ncle_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic            next_skips_length;
  logic            next_clocks_envelope;

  modport source (output valid, output op, output next_skips_length,
                  output next_clocks_envelope, input ready);
  modport sink (input valid, input op, input next_skips_length,
                input next_clocks_envelope, output ready);
endinterface

interface ncle_out_if;
  import ncle_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       channel_on;
  logic [VOL_W-1:0]           current_volume;
  logic [RELOAD_W-1:0]        timer_reload;

  modport source (output valid, output sample, output channel_on,
                  output current_volume, output timer_reload, input ready);
  modport sink (input valid, input sample, input channel_on,
                input current_volume, input timer_reload, output ready);
endinterface

interface ncle_cfg_if;
  import ncle_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/ncle_cfg_regs.sv =====
// Configuration register bank for the noise channel.
// Depends on ncle_pkg and the ncle_cfg_if interface.
module ncle_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  ncle_cfg_if.sink           cfg,
  output ncle_pkg::ncle_cfg_t regs
);
  import ncle_pkg::*;

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Store each field, masked to its width
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_DIVISOR_SELECT:  regs.divisor_select  <= cfg.data[2:0];
        CFG_FREQ_SHIFT:      regs.freq_shift      <= cfg.data[3:0];
        CFG_SHORT_MODE:      regs.short_mode      <= cfg.data[0];
        CFG_START_VOLUME:    regs.start_volume    <= cfg.data[3:0];
        CFG_ENVELOPE_UP:     regs.envelope_up     <= cfg.data[0];
        CFG_ENVELOPE_PERIOD: regs.envelope_period <= cfg.data[2:0];
        CFG_LENGTH_GATE:     regs.length_gate     <= cfg.data[0];
        CFG_OUTPUT_GAIN:     regs.output_gain     <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/noise_channel_lfsr_envelope.sv =====
// Top level of the noise channel: LFSR, length counter, volume envelope.
// Depends on ncle_pkg, the channel interfaces, ncle_cfg_regs and the macro header.
`include "noise_channel_lfsr_envelope_macros.svh"

// Noise channel of a handheld sound chip. Each event transaction updates the
// channel state and returns one result with the sample, enable bit, volume and
// frequency timer reload that the state after the event gives. The state
// registers and the result register are both written at the edge that
// accepts an event, so a new event is taken every cycle as long as the
// result register is empty or its result is being taken in the same cycle.
// A valid result appears in the cycle after acceptance. Register writes are
// always accepted and should only be made while no result is outstanding.
module noise_channel_lfsr_envelope (
  input logic        clk,
  input logic        rst,
  ncle_in_if.sink    in_item,
  ncle_out_if.source result,
  ncle_cfg_if.sink   cfg
);
  import ncle_pkg::*;

  ncle_cfg_t ctrl;

  logic [LFSR_W-1:0] noise_register, noise_register_next;
  logic [LEN_W-1:0]  length_count, length_count_next;
  logic [VOL_W-1:0]  volume, volume_next;
  logic [3:0]        envelope_timer, envelope_timer_next;
  logic              envelope_stopped, envelope_stopped_next;
  logic              enabled, enabled_next;
  logic              out_valid;

  logic                       accept;
  logic                       feedback;
  logic [7:0]                 magnitude;
  logic signed [SAMPLE_W-1:0] sample_next;
  logic [RELOAD_W-1:0]        reload_next;

  ncle_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (ctrl)
  );

  // Take an event whenever the result slot is free or draining
  assign in_item.ready = !out_valid || result.ready;
  assign accept        = in_item.valid && in_item.ready;
  assign feedback      = noise_register[0] ^ noise_register[1];

  // Work out the channel state after the event
  always_comb begin
    noise_register_next   = noise_register;
    length_count_next     = length_count;
    volume_next           = volume;
    envelope_timer_next   = envelope_timer;
    envelope_stopped_next = envelope_stopped;
    enabled_next          = enabled;
    unique case (in_item.op)
      OP_LFSR_STEP: begin
        noise_register_next = {feedback, noise_register[LFSR_TOP_BIT:1]};
        if (ctrl.short_mode) begin
          noise_register_next[LFSR_SHORT_BIT] = feedback;
        end
      end
      OP_LENGTH_CLOCK: begin
        if (ctrl.length_gate && length_count != '0) begin
          length_count_next = length_count - 7'd1;
          if (length_count == 7'd1) begin
            enabled_next = 1'b0;
          end
        end
      end
      OP_ENV_CLOCK: begin
        if (!envelope_stopped) begin
          if (envelope_timer > 4'd1) begin
            envelope_timer_next = envelope_timer - 4'd1;
          end else begin
            envelope_timer_next = env_reload(ctrl.envelope_period);
            if (ctrl.envelope_period != 3'd0) begin
              if (ctrl.envelope_up) begin
                if (volume < VOL_MAX) volume_next = volume + 4'd1;
                else envelope_stopped_next = 1'b1;
              end else begin
                if (volume != '0) volume_next = volume - 4'd1;
                else envelope_stopped_next = 1'b1;
              end
            end
          end
        end
      end
      OP_TRIGGER: begin
        enabled_next = !(ctrl.start_volume == '0 && !ctrl.envelope_up);
        if (length_count == '0) begin
          length_count_next = (ctrl.length_gate && in_item.next_skips_length)
                              ? LEN_SHORT : LEN_FULL;
        end
        envelope_stopped_next = 1'b0;
        envelope_timer_next   = env_reload(ctrl.envelope_period)
                                + {3'b000, in_item.next_clocks_envelope};
        volume_next           = ctrl.start_volume;
        noise_register_next   = LFSR_SEED;
      end
      default: ;
    endcase
  end

  // Form the sample from the new state, saturated to the signed byte
  always_comb begin
    magnitude = {4'b0000, volume_next} * {4'b0000, ctrl.output_gain};
    if (noise_register_next[0]) begin
      sample_next = (magnitude > 8'd128) ? -8'sd128 : signed'(~magnitude + 8'd1);
    end else begin
      sample_next = (magnitude > 8'd127) ? 8'sd127 : signed'(magnitude);
    end
    reload_next = {{(RELOAD_W-DIV_W){1'b0}}, DIVISOR_TABLE[ctrl.divisor_select]}
                  << ctrl.freq_shift;
  end

  // Advance the state on each accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_register   <= '0;
      length_count     <= '0;
      volume           <= '0;
      envelope_timer   <= '0;
      envelope_stopped <= 1'b0;
      enabled          <= 1'b0;
    end else if (accept) begin
      noise_register   <= noise_register_next;
      length_count     <= length_count_next;
      volume           <= volume_next;
      envelope_timer   <= envelope_timer_next;
      envelope_stopped <= envelope_stopped_next;
      enabled          <= enabled_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.sample         <= sample_next;
      result.channel_on     <= enabled_next;
      result.current_volume <= volume_next;
      result.timer_reload   <= reload_next;
    end
  end

  assign result.valid = out_valid;

  // Consistency checks
  `NCLE_ASSERT_NEXT(a_accept_gives_result, accept, out_valid, "event left no result")
  `NCLE_ASSERT_SAME(a_on_matches_state, out_valid, result.channel_on == enabled, "on bit differs")
  `NCLE_ASSERT_SAME(a_volume_matches_state, out_valid, result.current_volume == volume, "volume differs")
  `NCLE_ASSERT_NEXT(a_trigger_enables, accept && in_item.op == OP_TRIGGER && ctrl.start_volume != '0, enabled, "trigger left channel off")
  `NCLE_ASSERT_SAME(a_length_bound, 1'b1, length_count <= LEN_FULL, "length count above full")

endmodule
